// ===== hw/rtl/pretrigger_capture_ring_top_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the capture ring
// Clocked property checks that report through $error.
// ---------------------------------------------------------------------------
`ifndef PRETRIGGER_CAPTURE_RING_TOP_ASSERT_SVH
`define PRETRIGGER_CAPTURE_RING_TOP_ASSERT_SVH

// check while out of reset
`define PRC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// check at every edge, reset included
`define PRC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/prc_pkg.sv =====
// ---------------------------------------------------------------------------
// prc_pkg
// Shared codes, reset values and types of the capture ring.
// ---------------------------------------------------------------------------
package prc_pkg;

  localparam int REQ_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;
  localparam int REM_W      = 15;

  localparam logic [REQ_W-1:0] REQ_SAMPLE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TRIGGER = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REARM   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_READ    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_SPS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RING_LEN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRETRIG  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PAY  = 3'd4;

  localparam logic [14:0] RST_SPS      = 15'd4800;
  localparam logic [14:0] RST_RING_LEN = 15'd9600;
  localparam logic [13:0] RST_PRETRIG  = 14'd1440;
  localparam logic [3:0]  RST_CHANNELS = 4'd8;
  localparam logic [9:0]  RST_MIN_PAY  = 10'd64;

  typedef struct packed {
    logic             start;
    logic [REM_W-1:0] dividend;
    logic [REM_W-1:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic             done;
    logic [REM_W-1:0] value;
  } rem_rsp_t;

endpackage

// ===== hw/rtl/prc_rem.sv =====
// ---------------------------------------------------------------------------
// prc_rem
// Shared restoring remainder unit, one dividend bit per cycle.
// ---------------------------------------------------------------------------
module prc_rem (
  input  logic              clk,
  input  logic              rst_n,
  input  prc_pkg::rem_req_t req,
  output prc_pkg::rem_rsp_t rsp
);

  localparam int W   = prc_pkg::REM_W;
  localparam int CNT_W = $clog2(W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]     dvd_r, dvd_nxt;
  logic [W-1:0]     dvs_r, dvs_nxt;
  logic [W-1:0]     rem_r, rem_nxt;
  logic [W:0]       trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, dvd_r[W-1]};
    if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = W'(trial - {1'b0, dvs_r});
      end else begin
        rem_nxt = trial[W-1:0];
      end
      dvd_nxt = {dvd_r[W-2:0], 1'b0};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      rem_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done  = done_r;
  assign rsp.value = rem_r;

endmodule

// ===== hw/rtl/prc_store.sv =====
// ---------------------------------------------------------------------------
// prc_store
// Sample word memory with registered read and a clearing pass after reset.
// ---------------------------------------------------------------------------
module prc_store #(
  parameter int WORDS = 131072
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_en,
  input  logic [$clog2(WORDS)-1:0] wr_addr,
  input  logic [31:0]              wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(WORDS)-1:0] rd_addr,
  output logic [31:0]              rd_data,
  output logic                     clr_busy
);

  localparam int AW = $clog2(WORDS);

  logic [31:0]   mem [WORDS];
  logic          clr_r, clr_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic          we;
  logic [AW-1:0] wa;
  logic [31:0]   wd;
  logic [31:0]   rd_data_r;

  always_comb begin
    clr_nxt      = clr_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_r) begin
      clr_addr_nxt = clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(WORDS - 1)) begin
        clr_nxt = 1'b0;
      end
    end
    we = clr_r | wr_en;
    wa = clr_r ? clr_addr_r : wr_addr;
    wd = clr_r ? 32'd0 : wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clr_r      <= clr_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_r;

endmodule

// ===== hw/rtl/pretrigger_capture_ring_top.sv =====
// ---------------------------------------------------------------------------
// pretrigger_capture_ring_top
// Sample item: SMOD in the shared remainder unit (skipped when samples_per_second
// is 0), SCHK, then one store write per channel in SWR when the sample is stored.
// Trigger item: two passes through the remainder unit, none if already triggered.
// Rearm item: straight to FIN; read item: RWAIT through the registered memory read.
// Reset: synchronous; a clearing pass over DEPTH*MAX_CHANNELS words zeroes the
// store, no item is taken meanwhile, configuration writes are taken as ever.
// ---------------------------------------------------------------------------
module pretrigger_capture_ring_top #(
  parameter int DEPTH        = 16384,
  parameter int MAX_CHANNELS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [prc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [prc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [prc_pkg::REQ_W-1:0]       in_req_type,
  input  logic [15:0]                     in_sample_count,
  input  logic [9:0]                      in_data_size,
  input  logic signed [31:0]              in_chan_0,
  input  logic signed [31:0]              in_chan_1,
  input  logic signed [31:0]              in_chan_2,
  input  logic signed [31:0]              in_chan_3,
  input  logic signed [31:0]              in_chan_4,
  input  logic signed [31:0]              in_chan_5,
  input  logic signed [31:0]              in_chan_6,
  input  logic signed [31:0]              in_chan_7,
  input  logic [16:0]                     in_read_address,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [13:0]                     out_slot,
  output logic                            out_stored,
  output logic                            out_resynced,
  output logic                            out_bad_count,
  output logic                            out_is_triggered,
  output logic                            out_is_locked,
  output logic [7:0]                      out_completions,
  output logic [13:0]                     out_capture_start,
  output logic [13:0]                     out_capture_end,
  output logic signed [31:0]              out_read_data
);

  localparam int W           = prc_pkg::REM_W;
  localparam int PTR_W       = (DEPTH > 32768) ? 15 : $clog2(DEPTH);
  localparam int CC_W        = $clog2(MAX_CHANNELS + 1);
  localparam int CI_W        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int STORE_WORDS = DEPTH * MAX_CHANNELS;
  localparam int AW          = $clog2(STORE_WORDS);
  localparam logic [16:0] DEPTH_V = 17'(DEPTH);
  localparam logic [19:0] STORE_V = 20'(STORE_WORDS);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SMOD  = 4'd1;
  localparam logic [3:0] ST_SCHK  = 4'd2;
  localparam logic [3:0] ST_SWR   = 4'd3;
  localparam logic [3:0] ST_TLAST = 4'd4;
  localparam logic [3:0] ST_TPRE  = 4'd5;
  localparam logic [3:0] ST_TEND  = 4'd6;
  localparam logic [3:0] ST_RWAIT = 4'd7;
  localparam logic [3:0] ST_FIN   = 4'd8;

  logic [W-1:0]  sps_r, len_cfg_r;
  logic [13:0]   pre_r;
  logic [3:0]    chn_r;
  logic [9:0]    minp_r;

  logic [3:0]       state_r, state_nxt;
  logic [PTR_W-1:0] ptr_r, ptr_nxt;
  logic [PTR_W-1:0] last_r, last_nxt;
  logic [PTR_W-1:0] start_r, start_nxt;
  logic [PTR_W-1:0] end_r, end_nxt;
  logic             trig_r, trig_nxt;
  logic             lock_r, lock_nxt;
  logic [7:0]       comp_r, comp_nxt;

  logic [15:0]        cnt_r, cnt_nxt;
  logic [9:0]         dsize_r, dsize_nxt;
  logic signed [31:0] chan_r [MAX_CHANNELS];
  logic signed [31:0] chan_nxt [MAX_CHANNELS];
  logic signed [31:0] chan_in [8];
  logic [W-1:0]       m_r, m_nxt;
  logic [W-1:0]       lastm_r, lastm_nxt;
  logic [AW-1:0]      addr_r, addr_nxt;
  logic [CI_W-1:0]    ch_r, ch_nxt;
  logic [PTR_W-1:0]   slot_r, slot_nxt;
  logic               stored_r, stored_nxt;
  logic               resync_r, resync_nxt;
  logic               bad_r, bad_nxt;
  logic [31:0]        rdata_r, rdata_nxt;

  logic               ov_r, ov_nxt;
  logic [13:0]        o_slot_r, o_start_r, o_end_r;
  logic               o_stored_r, o_resync_r, o_bad_r, o_trig_r, o_lock_r;
  logic [7:0]         o_comp_r;
  logic [31:0]        o_rdata_r;
  logic               o_load;

  logic [W-1:0]             len;
  logic [CC_W-1:0]          cc;
  logic [PTR_W-1:0]         ptr_wrap;
  logic [PTR_W-1:0]         p;
  logic [PTR_W+CC_W-1:0]    prod;
  logic [W:0]               sum;
  logic [15:0]              inc;
  logic                     clr_busy;
  logic                     in_acc;
  logic                     mem_we, mem_re;
  logic [AW-1:0]            mem_raddr;
  logic [31:0]              mem_rdata;
  prc_pkg::rem_req_t        rem_req;
  prc_pkg::rem_rsp_t        rem_rsp;

  assign chan_in[0] = in_chan_0;
  assign chan_in[1] = in_chan_1;
  assign chan_in[2] = in_chan_2;
  assign chan_in[3] = in_chan_3;
  assign chan_in[4] = in_chan_4;
  assign chan_in[5] = in_chan_5;
  assign chan_in[6] = in_chan_6;
  assign chan_in[7] = in_chan_7;

  assign in_stall = clr_busy || (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    if (len_cfg_r == '0) begin
      len = W'(1);
    end else if ({2'b00, len_cfg_r} > DEPTH_V) begin
      len = DEPTH_V[W-1:0];
    end else begin
      len = len_cfg_r;
    end
    if (chn_r == 4'd0) begin
      cc = CC_W'(1);
    end else if (chn_r > 4'(MAX_CHANNELS)) begin
      cc = CC_W'(MAX_CHANNELS);
    end else begin
      cc = CC_W'(chn_r);
    end
    ptr_wrap = (W'(ptr_r) >= len) ? '0 : ptr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sps_r     <= prc_pkg::RST_SPS;
      len_cfg_r <= prc_pkg::RST_RING_LEN;
      pre_r     <= prc_pkg::RST_PRETRIG;
      chn_r     <= prc_pkg::RST_CHANNELS;
      minp_r    <= prc_pkg::RST_MIN_PAY;
    end else if (cfg_we) begin
      unique case (cfg_index)
        prc_pkg::CFG_SPS:      sps_r     <= cfg_wdata;
        prc_pkg::CFG_RING_LEN: len_cfg_r <= cfg_wdata;
        prc_pkg::CFG_PRETRIG:  pre_r     <= cfg_wdata[13:0];
        prc_pkg::CFG_CHANNELS: chn_r     <= cfg_wdata[3:0];
        prc_pkg::CFG_MIN_PAY:  minp_r    <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt  = state_r;
    ptr_nxt    = ptr_r;
    last_nxt   = last_r;
    start_nxt  = start_r;
    end_nxt    = end_r;
    trig_nxt   = trig_r;
    lock_nxt   = lock_r;
    comp_nxt   = comp_r;
    cnt_nxt    = cnt_r;
    dsize_nxt  = dsize_r;
    chan_nxt   = chan_r;
    m_nxt      = m_r;
    lastm_nxt  = lastm_r;
    addr_nxt   = addr_r;
    ch_nxt     = ch_r;
    slot_nxt   = slot_r;
    stored_nxt = stored_r;
    resync_nxt = resync_r;
    bad_nxt    = bad_r;
    rdata_nxt  = rdata_r;
    rem_req.start    = 1'b0;
    rem_req.dividend = '0;
    rem_req.divisor  = len;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = AW'(in_read_address);
    o_load    = 1'b0;
    p         = ptr_r;
    prod      = '0;
    sum       = '0;
    inc       = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cnt_nxt    = in_sample_count;
          dsize_nxt  = in_data_size;
          for (int i = 0; i < MAX_CHANNELS; i++) begin
            chan_nxt[i] = chan_in[i];
          end
          slot_nxt   = '0;
          stored_nxt = 1'b0;
          resync_nxt = 1'b0;
          bad_nxt    = 1'b0;
          rdata_nxt  = '0;
          unique case (in_req_type)
            prc_pkg::REQ_SAMPLE: begin
              ptr_nxt = ptr_wrap;
              if (sps_r == '0) begin
                m_nxt     = W'(ptr_wrap);
                state_nxt = ST_SCHK;
              end else begin
                rem_req.start    = 1'b1;
                rem_req.dividend = W'(ptr_wrap);
                rem_req.divisor  = sps_r;
                state_nxt        = ST_SMOD;
              end
            end
            prc_pkg::REQ_TRIGGER: begin
              if (trig_r) begin
                state_nxt = ST_FIN;
              end else begin
                rem_req.start    = 1'b1;
                rem_req.dividend = W'(last_r);
                state_nxt        = ST_TLAST;
              end
            end
            prc_pkg::REQ_REARM: begin
              trig_nxt  = 1'b0;
              lock_nxt  = 1'b0;
              comp_nxt  = '0;
              state_nxt = ST_FIN;
            end
            prc_pkg::REQ_READ: begin
              if ({3'b000, in_read_address} < STORE_V) begin
                mem_re    = 1'b1;
                state_nxt = ST_RWAIT;
              end else begin
                state_nxt = ST_FIN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SMOD: begin
        if (rem_rsp.done) begin
          m_nxt     = rem_rsp.value;
          state_nxt = ST_SCHK;
        end
      end
      ST_SCHK: begin
        if ({1'b0, m_r} != cnt_r) begin
          if (cnt_r < {1'b0, len}) begin
            p          = PTR_W'(cnt_r);
            resync_nxt = 1'b1;
          end else begin
            bad_nxt = 1'b1;
          end
        end
        last_nxt   = p;
        slot_nxt   = p;
        stored_nxt = (dsize_r >= minp_r) && !(trig_r && lock_r);
        prod       = (PTR_W + CC_W)'(p) * (PTR_W + CC_W)'(cc);
        addr_nxt   = AW'(prod);
        ch_nxt     = '0;
        if (trig_r && (p == end_r)) begin
          if (comp_r != 8'hFF) begin
            comp_nxt = comp_r + 8'd1;
          end
          lock_nxt = 1'b1;
        end
        inc = 16'(p) + 16'd1;
        ptr_nxt = (inc >= {1'b0, len}) ? '0 : PTR_W'(inc);
        state_nxt = stored_nxt ? ST_SWR : ST_FIN;
      end
      ST_SWR: begin
        mem_we   = 1'b1;
        addr_nxt = addr_r + AW'(1);
        ch_nxt   = ch_r + CI_W'(1);
        if (CC_W'(ch_r) == (cc - CC_W'(1))) begin
          state_nxt = ST_FIN;
        end
      end
      ST_TLAST: begin
        if (rem_rsp.done) begin
          lastm_nxt        = rem_rsp.value;
          rem_req.start    = 1'b1;
          rem_req.dividend = W'(pre_r);
          state_nxt        = ST_TPRE;
        end
      end
      ST_TPRE: begin
        if (rem_rsp.done) begin
          sum = {1'b0, lastm_r} + {1'b0, len} - {1'b0, rem_rsp.value};
          if (sum >= {1'b0, len}) begin
            sum = sum - {1'b0, len};
          end
          start_nxt = PTR_W'(sum);
          state_nxt = ST_TEND;
        end
      end
      ST_TEND: begin
        sum = (W + 1)'(start_r) + {1'b0, len} - (W + 1)'(1);
        if (sum >= {1'b0, len}) begin
          sum = sum - {1'b0, len};
        end
        end_nxt   = PTR_W'(sum);
        trig_nxt  = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_RWAIT: begin
        rdata_nxt = mem_rdata;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!ov_r || !out_stall) begin
          o_load    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    ov_nxt = o_load ? 1'b1 : (ov_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ptr_r   <= '0;
      last_r  <= '0;
      start_r <= '0;
      end_r   <= '0;
      trig_r  <= 1'b0;
      lock_r  <= 1'b0;
      comp_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      last_r  <= last_nxt;
      start_r <= start_nxt;
      end_r   <= end_nxt;
      trig_r  <= trig_nxt;
      lock_r  <= lock_nxt;
      comp_r  <= comp_nxt;
      ov_r    <= ov_nxt;
    end
    cnt_r    <= cnt_nxt;
    dsize_r  <= dsize_nxt;
    chan_r   <= chan_nxt;
    m_r      <= m_nxt;
    lastm_r  <= lastm_nxt;
    addr_r   <= addr_nxt;
    ch_r     <= ch_nxt;
    slot_r   <= slot_nxt;
    stored_r <= stored_nxt;
    resync_r <= resync_nxt;
    bad_r    <= bad_nxt;
    rdata_r  <= rdata_nxt;
    if (o_load) begin
      o_slot_r   <= 14'(slot_r);
      o_stored_r <= stored_r;
      o_resync_r <= resync_r;
      o_bad_r    <= bad_r;
      o_trig_r   <= trig_r;
      o_lock_r   <= lock_r;
      o_comp_r   <= comp_r;
      o_start_r  <= 14'(start_r);
      o_end_r    <= 14'(end_r);
      o_rdata_r  <= rdata_r;
    end
  end

  prc_rem u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rem_req),
    .rsp   (rem_rsp)
  );

  prc_store #(
    .WORDS (STORE_WORDS)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (mem_we),
    .wr_addr  (addr_r),
    .wr_data  (chan_r[ch_r]),
    .rd_en    (mem_re),
    .rd_addr  (mem_raddr),
    .rd_data  (mem_rdata),
    .clr_busy (clr_busy)
  );

  assign out_valid         = ov_r;
  assign out_slot          = o_slot_r;
  assign out_stored        = o_stored_r;
  assign out_resynced      = o_resync_r;
  assign out_bad_count     = o_bad_r;
  assign out_is_triggered  = o_trig_r;
  assign out_is_locked     = o_lock_r;
  assign out_completions   = o_comp_r;
  assign out_capture_start = o_start_r;
  assign out_capture_end   = o_end_r;
  assign out_read_data     = o_rdata_r;

endmodule

// ===== hw/rtl/prc_checker.sv =====
// ---------------------------------------------------------------------------
// prc_checker
// Port-level checks of the capture ring, bound to the top level.
// ---------------------------------------------------------------------------
`include "pretrigger_capture_ring_top_assert.svh"

module prc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [13:0]       out_slot,
  input logic              out_resynced,
  input logic              out_bad_count,
  input logic              out_is_triggered,
  input logic              out_is_locked,
  input logic signed [31:0] out_read_data
);

  logic [1:0] pend_r, pend_nxt;

  always_comb begin
    pend_nxt = pend_r;
    if (in_valid && !in_stall) begin
      pend_nxt = pend_nxt + 2'd1;
    end
    if (out_valid && !out_stall) begin
      pend_nxt = pend_nxt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `PRC_ASSERT_ALWAYS(a_clear_after_reset, clk, !rst_n |=> in_stall, "item taken during clear")
  `PRC_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_slot) && $stable(out_read_data), "stalled result changed")
  `PRC_ASSERT(a_no_extra, clk, rst_n, out_valid |-> pend_r != 2'd0 && pend_r != 2'd3, "result without item")
  `PRC_ASSERT(a_lock_trig, clk, rst_n, out_valid |-> !out_is_locked || out_is_triggered, "locked without trigger")
  `PRC_ASSERT(a_bad_resync, clk, rst_n, out_valid |-> !(out_bad_count && out_resynced), "bad count and resync")

endmodule

bind pretrigger_capture_ring_top prc_checker u_prc_checker (.*);

// ===== verif/pretrigger_capture_ring_top_test.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// pretrigger_capture_ring_top_test
// Self-checking bench for the capture ring. A short table of directed items
// runs first, followed by phases of random items under changing register
// settings and idle patterns. Each item's result is predicted by an in-bench
// copy of the ring or given by its row and compared field by field, in order.
// ---------------------------------------------------------------------------
module pretrigger_capture_ring_top_test;

  localparam int DEPTH       = 16384;
  localparam int MAX_CH      = 8;
  localparam int STORE_WORDS = DEPTH * MAX_CH;
  localparam int QUIET_LIMIT = 400000;
  localparam int HOLD_CYCLES = 3000;
  localparam int DIR_N       = 31;
  localparam int PHASE_N     = 7;

  typedef struct packed {
    logic [1:0]       req;
    logic [15:0]      cnt;
    logic [9:0]       dsize;
    logic [7:0][31:0] chan;
    logic [16:0]      raddr;
  } ring_item_t;

  typedef struct packed {
    logic [13:0] slot;
    logic        stored;
    logic        resynced;
    logic        bad_count;
    logic        triggered;
    logic        locked;
    logic [7:0]  completions;
    logic [13:0] cap_start;
    logic [13:0] cap_end;
    logic [31:0] rdata;
  } ring_result_t;

  typedef struct {
    bit           is_cfg;
    logic [2:0]   cidx;
    int           cval;
    ring_item_t   item;
    bit           fixed;
    ring_result_t res;
  } dir_row_t;

  typedef struct {
    int sps;
    int len;
    int pre;
    int cc;
    int minpay;
    int n;
    int mode;
    int sample_pct;
    bit rearm_ok;
    bit hold;
  } phase_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [prc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [prc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [prc_pkg::REQ_W-1:0]      in_req_type = '0;
  logic [15:0]                    in_sample_count = '0;
  logic [9:0]                     in_data_size = '0;
  logic signed [31:0]             in_chan_0 = '0;
  logic signed [31:0]             in_chan_1 = '0;
  logic signed [31:0]             in_chan_2 = '0;
  logic signed [31:0]             in_chan_3 = '0;
  logic signed [31:0]             in_chan_4 = '0;
  logic signed [31:0]             in_chan_5 = '0;
  logic signed [31:0]             in_chan_6 = '0;
  logic signed [31:0]             in_chan_7 = '0;
  logic [16:0]                    in_read_address = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [13:0]                    out_slot;
  logic                           out_stored;
  logic                           out_resynced;
  logic                           out_bad_count;
  logic                           out_is_triggered;
  logic                           out_is_locked;
  logic [7:0]                     out_completions;
  logic [13:0]                    out_capture_start;
  logic [13:0]                    out_capture_end;
  logic signed [31:0]             out_read_data;

  pretrigger_capture_ring_top #(
    .DEPTH(DEPTH),
    .MAX_CHANNELS(MAX_CH)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_req_type(in_req_type),
    .in_sample_count(in_sample_count),
    .in_data_size(in_data_size),
    .in_chan_0(in_chan_0),
    .in_chan_1(in_chan_1),
    .in_chan_2(in_chan_2),
    .in_chan_3(in_chan_3),
    .in_chan_4(in_chan_4),
    .in_chan_5(in_chan_5),
    .in_chan_6(in_chan_6),
    .in_chan_7(in_chan_7),
    .in_read_address(in_read_address),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_slot(out_slot),
    .out_stored(out_stored),
    .out_resynced(out_resynced),
    .out_bad_count(out_bad_count),
    .out_is_triggered(out_is_triggered),
    .out_is_locked(out_is_locked),
    .out_completions(out_completions),
    .out_capture_start(out_capture_start),
    .out_capture_end(out_capture_end),
    .out_read_data(out_read_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ring copy: registers, pointers, flags, store
  int          c_sps = 4800;
  int          c_len = 9600;
  int          c_pre = 1440;
  int          c_cc = 8;
  int          c_minpay = 64;
  int          wp = 0;
  int          lastw = 0;
  int          smark = 0;
  int          emark = 0;
  int          comp = 0;
  bit          trig = 1'b0;
  bit          lock = 1'b0;
  logic [31:0] store_mem [STORE_WORDS];

  ring_result_t expected_capture_q [$];
  ring_result_t got;
  ring_result_t want;
  int           mismatches = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  int           holds_asked = 0;
  int           holds_seen = 0;
  int           hold_left = 0;
  int           quiet_cycles = 0;
  int           ri;
  int           pi;
  int           ki;
  dir_row_t     dir_rows [DIR_N];
  phase_t       phases [PHASE_N];

  function automatic int ring_len_eff();
    if (c_len < 1) return 1;
    if (c_len > DEPTH) return DEPTH;
    return c_len;
  endfunction

  function automatic int chan_count_eff();
    if (c_cc < 1) return 1;
    if (c_cc > MAX_CH) return MAX_CH;
    return c_cc;
  endfunction

  function automatic ring_result_t predict_ring_result(input ring_item_t it);
    ring_result_t r;
    int len;
    int cc;
    int m;
    int a;
    int i;
    int last;
    int pre;
    r = '0;
    len = ring_len_eff();
    cc = chan_count_eff();
    case (it.req)
      prc_pkg::REQ_SAMPLE: begin
        if (wp >= len) wp = 0;
        m = (c_sps == 0) ? wp : wp % c_sps;
        if (m != int'(it.cnt)) begin
          if (int'(it.cnt) < len) begin
            wp = int'(it.cnt);
            r.resynced = 1'b1;
          end else begin
            r.bad_count = 1'b1;
          end
        end
        lastw = wp;
        r.slot = wp[13:0];
        if (int'(it.dsize) >= c_minpay && !(trig && lock)) begin
          for (i = 0; i < cc; i++) begin
            a = wp * cc + i;
            if (a < STORE_WORDS) store_mem[a] = it.chan[i];
          end
          r.stored = 1'b1;
        end
        if (trig && wp == emark) begin
          if (comp < 255) comp++;
          lock = 1'b1;
        end
        wp++;
        if (wp >= len) wp = 0;
      end
      prc_pkg::REQ_TRIGGER: begin
        if (!trig) begin
          last = lastw % len;
          pre = c_pre % len;
          trig = 1'b1;
          smark = (last + len - pre) % len;
          emark = (smark + len - 1) % len;
        end
      end
      prc_pkg::REQ_REARM: begin
        trig = 1'b0;
        lock = 1'b0;
        comp = 0;
      end
      default: begin
        if (int'(it.raddr) < STORE_WORDS) r.rdata = store_mem[it.raddr];
      end
    endcase
    r.triggered = trig;
    r.locked = lock;
    r.completions = comp[7:0];
    r.cap_start = smark[13:0];
    r.cap_end = emark[13:0];
    return r;
  endfunction

  function automatic ring_item_t make_item(input int sample_pct, input bit rearm_ok);
    ring_item_t it;
    int len;
    int cc;
    int w;
    int j;
    int i;
    len = ring_len_eff();
    cc = chan_count_eff();
    for (i = 0; i < MAX_CH; i++) it.chan[i] = $urandom;
    it.cnt = 16'($urandom);
    it.dsize = 10'($urandom);
    it.raddr = 17'($urandom);
    if ($urandom_range(0, 99) < sample_pct) begin
      it.req = prc_pkg::REQ_SAMPLE;
      w = (wp >= len) ? 0 : wp;
      j = $urandom_range(0, 99);
      if (j < 80) it.cnt = 16'((c_sps == 0) ? w : w % c_sps);
      else if (j < 86) it.cnt = 16'(emark);
      else if (j < 93) it.cnt = 16'($urandom_range(0, len - 1));
      if ($urandom_range(0, 3) != 0) it.dsize = 10'($urandom_range(c_minpay, 1023));
    end else begin
      j = $urandom_range(0, 9);
      if (j < 3) it.req = prc_pkg::REQ_TRIGGER;
      else if (j < 5 && rearm_ok) it.req = prc_pkg::REQ_REARM;
      else it.req = prc_pkg::REQ_READ;
      if (it.req == prc_pkg::REQ_READ && $urandom_range(0, 3) != 0)
        it.raddr = 17'($urandom_range(0, len - 1) * cc + $urandom_range(0, cc - 1));
    end
    return it;
  endfunction

  function automatic dir_row_t item_row(input logic [1:0] req, input int cnt, input int dsize,
                                        input logic [31:0] c0, input logic [31:0] c1,
                                        input int raddr);
    dir_row_t d;
    int i;
    d.is_cfg = 1'b0;
    d.cidx = '0;
    d.cval = 0;
    d.item.req = req;
    d.item.cnt = cnt[15:0];
    d.item.dsize = dsize[9:0];
    for (i = 0; i < MAX_CH; i++) d.item.chan[i] = i[0] ? c1 : c0;
    d.item.raddr = raddr[16:0];
    d.fixed = 1'b0;
    d.res = '0;
    return d;
  endfunction

  function automatic dir_row_t fixed_row(input logic [1:0] req, input int cnt, input int dsize,
                                         input logic [31:0] c0, input logic [31:0] c1,
                                         input int raddr, input ring_result_t e);
    dir_row_t d;
    d = item_row(req, cnt, dsize, c0, c1, raddr);
    d.fixed = 1'b1;
    d.res = e;
    return d;
  endfunction

  function automatic dir_row_t cfg_row(input logic [2:0] idx, input int val);
    dir_row_t d;
    d = item_row(prc_pkg::REQ_READ, 0, 0, '0, '0, 0);
    d.is_cfg = 1'b1;
    d.cidx = idx;
    d.cval = val;
    return d;
  endfunction

  function automatic ring_result_t res_of(input int slot, input bit st, input bit rs,
                                          input bit bad, input bit tr, input bit lk,
                                          input int cm, input int cs, input int ce,
                                          input logic [31:0] rd);
    ring_result_t r;
    r.slot = slot[13:0];
    r.stored = st;
    r.resynced = rs;
    r.bad_count = bad;
    r.triggered = tr;
    r.locked = lk;
    r.completions = cm[7:0];
    r.cap_start = cs[13:0];
    r.cap_end = ce[13:0];
    r.rdata = rd;
    return r;
  endfunction

  function automatic int idle_gap();
    int n;
    n = 0;
    while ($urandom_range(0, 99) < send_idle_pct) n++;
    return n;
  endfunction

  function automatic void set_idle_mode(input int mode);
    case (mode)
      0: begin
        send_idle_pct = 29;
        recv_idle_pct = 46;
      end
      1: begin
        send_idle_pct = 46;
        recv_idle_pct = 29;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endfunction

  task automatic cfg_write(input logic [2:0] idx, input int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[14:0];
    @(posedge clk);
    case (idx)
      prc_pkg::CFG_SPS:      c_sps = val & 32'h7fff;
      prc_pkg::CFG_RING_LEN: c_len = val & 32'h7fff;
      prc_pkg::CFG_PRETRIG:  c_pre = val & 32'h3fff;
      prc_pkg::CFG_CHANNELS: c_cc = val & 32'hf;
      prc_pkg::CFG_MIN_PAY:  c_minpay = val & 32'h3ff;
      default: ;
    endcase
  endtask

  task automatic pause(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    while (expected_capture_q.size() != 0) @(posedge clk);
  endtask

  task automatic offer(input ring_item_t it, input bit fixed, input ring_result_t fixed_res);
    ring_result_t r;
    in_valid <= 1'b1;
    in_req_type <= it.req;
    in_sample_count <= it.cnt;
    in_data_size <= it.dsize;
    in_chan_0 <= it.chan[0];
    in_chan_1 <= it.chan[1];
    in_chan_2 <= it.chan[2];
    in_chan_3 <= it.chan[3];
    in_chan_4 <= it.chan[4];
    in_chan_5 <= it.chan[5];
    in_chan_6 <= it.chan[6];
    in_chan_7 <= it.chan[7];
    in_read_address <= it.raddr;
    do @(posedge clk); while (in_stall !== 1'b0);
    r = predict_ring_result(it);
    if (fixed) r = fixed_res;
    expected_capture_q.push_back(r);
  endtask

  always @(posedge clk) begin
    if (holds_asked != holds_seen) begin
      holds_seen = holds_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (out_valid === 1'b1 && out_stall === 1'b0) begin
      got = '{out_slot, out_stored, out_resynced, out_bad_count, out_is_triggered,
              out_is_locked, out_completions, out_capture_start, out_capture_end,
              out_read_data};
      if (expected_capture_q.size() == 0) begin
        if (mismatches < 10) $display("%0t: result item with none expected", $time);
        mismatches++;
      end else begin
        want = expected_capture_q.pop_front();
        if (got.slot !== want.slot || got.stored !== want.stored ||
            got.resynced !== want.resynced || got.bad_count !== want.bad_count ||
            got.triggered !== want.triggered || got.locked !== want.locked ||
            got.completions !== want.completions || got.cap_start !== want.cap_start ||
            got.cap_end !== want.cap_end || got.rdata !== want.rdata) begin
          if (mismatches < 10) begin
            $display("%0t: mismatch (slot stored resync bad trig lock comp start end data)",
                     $time);
            $display("  expected %0d %0b %0b %0b %0b %0b %0d %0d %0d %h", want.slot,
                     want.stored, want.resynced, want.bad_count, want.triggered,
                     want.locked, want.completions, want.cap_start, want.cap_end,
                     want.rdata);
            $display("  actual   %0d %0b %0b %0b %0b %0b %0d %0d %0d %h", got.slot,
                     got.stored, got.resynced, got.bad_count, got.triggered,
                     got.locked, got.completions, got.cap_start, got.cap_end,
                     got.rdata);
          end
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** pretrigger_capture_ring_top: FAILED **");
      $finish;
    end
  end

  initial begin
    for (ri = 0; ri < STORE_WORDS; ri++) store_mem[ri] = '0;
    dir_rows = '{
      fixed_row(prc_pkg::REQ_READ, 0, 0, '0, '0, 0,
                res_of(0, 0, 0, 0, 0, 0, 0, 0, 0, '0)),
      fixed_row(prc_pkg::REQ_READ, 0, 0, '0, '0, 131071,
                res_of(0, 0, 0, 0, 0, 0, 0, 0, 0, '0)),
      fixed_row(prc_pkg::REQ_SAMPLE, 0, 1023, 32'h8000_0000, 32'h7fff_ffff, 0,
                res_of(0, 1, 0, 0, 0, 0, 0, 0, 0, '0)),
      fixed_row(prc_pkg::REQ_READ, 0, 0, '0, '0, 0,
                res_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h8000_0000)),
      fixed_row(prc_pkg::REQ_SAMPLE, 65535, 0, '0, 32'hffff_ffff, 0,
                res_of(1, 0, 0, 1, 0, 0, 0, 0, 0, '0)),
      item_row(prc_pkg::REQ_SAMPLE, 9600, 64, 32'hffff_ffff, '0, 0),
      item_row(prc_pkg::REQ_SAMPLE, 9599, 63, 32'h0f0f_0f0f, 32'hf0f0_f0f0, 0),
      item_row(prc_pkg::REQ_SAMPLE, 0, 64, 32'h1234_5678, 32'h9abc_def0, 0),
      fixed_row(prc_pkg::REQ_TRIGGER, 0, 0, '0, '0, 0,
                res_of(0, 0, 0, 0, 1, 0, 0, 8160, 8159, '0)),
      item_row(prc_pkg::REQ_TRIGGER, 0, 0, '0, '0, 0),
      item_row(prc_pkg::REQ_SAMPLE, 8159, 100, 32'ha5a5_a5a5, 32'h5a5a_5a5a, 0),
      item_row(prc_pkg::REQ_SAMPLE, 8160, 100, 32'h1111_1111, 32'h2222_2222, 0),
      item_row(prc_pkg::REQ_SAMPLE, 8159, 1023, 32'h3333_3333, 32'h4444_4444, 0),
      item_row(prc_pkg::REQ_READ, 0, 0, '0, '0, 8159 * 8),
      item_row(prc_pkg::REQ_REARM, 0, 0, '0, '0, 0),
      cfg_row(prc_pkg::CFG_SPS, 0),
      cfg_row(prc_pkg::CFG_RING_LEN, 16),
      cfg_row(prc_pkg::CFG_PRETRIG, 14),
      cfg_row(prc_pkg::CFG_CHANNELS, 1),
      cfg_row(prc_pkg::CFG_MIN_PAY, 1023),
      item_row(prc_pkg::REQ_SAMPLE, 5, 1023, 32'hdead_beef, 32'h0bad_f00d, 0),
      item_row(prc_pkg::REQ_SAMPLE, 6, 1022, 32'h5555_5555, 32'haaaa_aaaa, 0),
      item_row(prc_pkg::REQ_SAMPLE, 16, 1023, 32'h7777_7777, 32'h8888_8888, 0),
      item_row(prc_pkg::REQ_TRIGGER, 0, 0, '0, '0, 0),
      item_row(prc_pkg::REQ_READ, 0, 0, '0, '0, 5),
      cfg_row(prc_pkg::CFG_CHANNELS, 15),
      cfg_row(prc_pkg::CFG_MIN_PAY, 0),
      item_row(prc_pkg::REQ_SAMPLE, 9, 0, 32'hcafe_0001, 32'hcafe_0002, 0),
      item_row(prc_pkg::REQ_READ, 0, 0, '0, '0, 79),
      item_row(prc_pkg::REQ_SAMPLE, 10, 0, 32'h0000_0001, 32'hfffe_ffff, 0),
      item_row(prc_pkg::REQ_READ, 0, 0, '0, '0, 131071)
    };
    phases = '{
      '{4800, 9600, 1440, 8, 64, 120, 0, 75, 1'b1, 1'b0},
      '{0, 16, 0, 1, 0, 200, 0, 75, 1'b1, 1'b0},
      '{16384, 16384, 16382, 8, 1023, 100, 0, 75, 1'b1, 1'b0},
      '{7, 20, 5, 3, 100, 160, 1, 75, 1'b1, 1'b0},
      '{1, 2, 0, 2, 0, 600, 1, 92, 1'b0, 1'b1},
      '{100, 50, 48, 15, 1, 150, 2, 75, 1'b1, 1'b0},
      '{5, 37, 35, 4, 512, 100, 2, 75, 1'b1, 1'b0}
    };
    set_idle_mode(0);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (ri = 0; ri < DIR_N; ri++) begin
      if (dir_rows[ri].is_cfg) begin
        in_valid <= 1'b0;
        drain();
        cfg_write(dir_rows[ri].cidx, dir_rows[ri].cval);
      end else begin
        cfg_we <= 1'b0;
        pause(idle_gap());
        offer(dir_rows[ri].item, dir_rows[ri].fixed, dir_rows[ri].res);
      end
    end

    for (pi = 0; pi < PHASE_N; pi++) begin
      in_valid <= 1'b0;
      drain();
      set_idle_mode(phases[pi].mode);
      cfg_write(prc_pkg::CFG_SPS, phases[pi].sps);
      cfg_write(prc_pkg::CFG_RING_LEN, phases[pi].len);
      cfg_write(prc_pkg::CFG_PRETRIG, phases[pi].pre);
      cfg_write(prc_pkg::CFG_CHANNELS, phases[pi].cc);
      cfg_write(prc_pkg::CFG_MIN_PAY, phases[pi].minpay);
      cfg_we <= 1'b0;
      for (ki = 0; ki < phases[pi].n; ki++) begin
        if (phases[pi].hold && ki == phases[pi].n / 4) holds_asked++;
        pause(idle_gap());
        offer(make_item(phases[pi].sample_pct, phases[pi].rearm_ok), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    drain();
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("** pretrigger_capture_ring_top: PASSED **");
    end else begin
      $display("** pretrigger_capture_ring_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/prc_pkg.sv
hw/rtl/prc_rem.sv
hw/rtl/prc_store.sv
hw/rtl/pretrigger_capture_ring_top.sv
hw/rtl/prc_checker.sv
verif/pretrigger_capture_ring_top_test.sv
